// ===== hdl/wou_pkg.sv =====
// Shared types, constants and helper functions of the weight optimizer update block.
`default_nettype none
package wou_pkg;

  localparam int NUM_WEIGHTS = 1024;
  localparam int IDX_W       = $clog2(NUM_WEIGHTS);
  localparam int Q_W         = 32;
  localparam int FRAC_W      = 24;
  localparam int CFG_W       = 25;
  localparam int ROW_W       = 5 * Q_W;
  localparam int SQ_RAD_W    = 56;
  localparam int SQ_ROOT_W   = 28;
  localparam int SQ_CNT_W    = 5;
  localparam int DIV_BITS    = SQ_ROOT_W + FRAC_W;
  localparam int DIV_CNT_W   = 6;

  localparam logic [CFG_W-1:0] Q_ONE = 25'h100_0000;

  localparam logic [1:0] MODE_PLAIN    = 2'd0;
  localparam logic [1:0] MODE_NESTEROV = 2'd1;
  localparam logic [1:0] MODE_ADADELTA = 2'd2;
  localparam logic [1:0] MODE_BOTH     = 2'd3;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_LRATE = 2'd1;
  localparam logic [1:0] REG_DECAY = 2'd2;
  localparam logic [1:0] REG_EPS   = 2'd3;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_READ, S_STEP, S_GG, S_DG, S_CGG, S_GWAIT, S_GSUM,
    S_SQN_GO, S_SQN, S_SQD_GO, S_SQD, S_DIV_GO, S_DIV,
    S_RG, S_RGWAIT, S_SS, S_DD, S_CSS, S_DWAIT, S_DSUM,
    S_CARRY, S_CWAIT, S_VEL, S_TRUE, S_VIS, S_PLAIN, S_WRITE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_LATCH,
    OP_MUL_STEP, OP_MUL_GG, OP_MUL_DG, OP_MUL_CGG, OP_MUL_RG,
    OP_MUL_SS, OP_MUL_DD, OP_MUL_CSS, OP_MUL_CARRY,
    OP_GSUM, OP_DSUM, OP_SQN_GO, OP_SQD_GO, OP_DIV_GO,
    OP_VEL, OP_TRUE, OP_VIS, OP_PLAIN, OP_WRITE
  } dp_op_t;

  typedef enum logic [2:0] {
    DST_STEP, DST_GG, DST_T1, DST_T2, DST_S, DST_SS, DST_CARRY
  } mul_dst_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       is_load;
    logic       sq_done;
    logic       div_done;
  } dp_status_t;

  localparam logic signed [41:0] SAT_MAX = 42'sd2147483647;
  localparam logic signed [41:0] SAT_MIN = -42'sd2147483648;

  // Returns the saturation flag above the clipped 32-bit value.
  function automatic logic [Q_W:0] sat_q(input logic signed [41:0] v);
    logic [Q_W:0] res;
    if (v > SAT_MAX) begin
      res = {1'b1, 32'h7FFF_FFFF};
    end else if (v < SAT_MIN) begin
      res = {1'b1, 32'h8000_0000};
    end else begin
      res = {1'b0, v[Q_W-1:0]};
    end
    return res;
  endfunction

  function automatic logic signed [41:0] sx42(input logic signed [Q_W-1:0] x);
    return 42'(x);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/wou_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module wou_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/wou_ctrl.sv =====
// Sequencing state machine of the weight optimizer update block.
`default_nettype none
module wou_ctrl import wou_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire dp_status_t status,
  output dp_cmd_t         ctl,
  output logic            busy,
  output logic            done
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl.op     = OP_NONE;
    busy       = 1'b1;
    done       = 1'b0;
    unique case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.op     = OP_ACCEPT;
          state_next = S_READ;
        end
      end
      S_READ: begin
        ctl.op     = OP_LATCH;
        state_next = (status.is_load == CMD_LOAD) ? S_WRITE : S_STEP;
      end
      S_STEP: begin
        ctl.op = OP_MUL_STEP;
        if (status.mode == MODE_ADADELTA || status.mode == MODE_BOTH) begin
          state_next = S_GG;
        end else if (status.mode == MODE_NESTEROV) begin
          state_next = S_CARRY;
        end else begin
          state_next = S_CWAIT;
        end
      end
      S_GG: begin
        ctl.op     = OP_MUL_GG;
        state_next = S_DG;
      end
      S_DG: begin
        ctl.op     = OP_MUL_DG;
        state_next = S_CGG;
      end
      S_CGG: begin
        ctl.op     = OP_MUL_CGG;
        state_next = S_GWAIT;
      end
      S_GWAIT: state_next = S_GSUM;
      S_GSUM: begin
        ctl.op     = OP_GSUM;
        state_next = S_SQN_GO;
      end
      S_SQN_GO: begin
        ctl.op     = OP_SQN_GO;
        state_next = S_SQN;
      end
      S_SQN: begin
        if (status.sq_done) begin
          state_next = S_SQD_GO;
        end
      end
      S_SQD_GO: begin
        ctl.op     = OP_SQD_GO;
        state_next = S_SQD;
      end
      S_SQD: begin
        if (status.sq_done) begin
          state_next = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        ctl.op     = OP_DIV_GO;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_RG;
        end
      end
      S_RG: begin
        ctl.op     = OP_MUL_RG;
        state_next = S_RGWAIT;
      end
      S_RGWAIT: state_next = S_SS;
      S_SS: begin
        ctl.op     = OP_MUL_SS;
        state_next = S_DD;
      end
      S_DD: begin
        ctl.op     = OP_MUL_DD;
        state_next = S_CSS;
      end
      S_CSS: begin
        ctl.op     = OP_MUL_CSS;
        state_next = S_DWAIT;
      end
      S_DWAIT: state_next = S_DSUM;
      S_DSUM: begin
        ctl.op     = OP_DSUM;
        state_next = (status.mode == MODE_ADADELTA) ? S_PLAIN : S_CARRY;
      end
      S_CARRY: begin
        ctl.op     = OP_MUL_CARRY;
        state_next = S_CWAIT;
      end
      S_CWAIT: state_next = (status.mode == MODE_PLAIN) ? S_PLAIN : S_VEL;
      S_VEL: begin
        ctl.op     = OP_VEL;
        state_next = S_TRUE;
      end
      S_TRUE: begin
        ctl.op     = OP_TRUE;
        state_next = S_VIS;
      end
      S_VIS: begin
        ctl.op     = OP_VIS;
        state_next = S_WRITE;
      end
      S_PLAIN: begin
        ctl.op     = OP_PLAIN;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        ctl.op     = OP_WRITE;
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/wou_dp.sv =====
// Datapath: weight table, configuration registers, multiplier, square-root and divide units.
`default_nettype none
module wou_dp import wou_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire dp_cmd_t                 ctl,
  output dp_status_t                   status,
  input  wire logic                    cmd,
  input  wire logic [IDX_W-1:0]        weight_index,
  input  wire logic signed [Q_W-1:0]   operand_value,
  input  wire logic                    cfg_valid,
  input  wire logic [1:0]              cfg_index,
  input  wire logic [CFG_W-1:0]        cfg_data,
  output logic [IDX_W-1:0]             result_index,
  output logic signed [Q_W-1:0]        new_weight,
  output logic                         saturated
);

  // Configuration registers and their clamped views.
  logic [1:0]       mode_r;
  logic [CFG_W-1:0] lr_r, df_r, eps_r;
  logic [CFG_W-1:0] lr_c, d_c, c_c, eps_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_r <= MODE_ADADELTA;
      lr_r   <= 25'd167772;
      df_r   <= 25'd15099494;
      eps_r  <= 25'd17;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MODE:  mode_r <= cfg_data[1:0];
        REG_LRATE: lr_r   <= cfg_data;
        REG_DECAY: df_r   <= cfg_data;
        REG_EPS:   eps_r  <= cfg_data;
        default:   mode_r <= mode_r;
      endcase
    end
  end

  always_comb begin
    lr_c  = (lr_r > Q_ONE) ? Q_ONE : lr_r;
    d_c   = (df_r > Q_ONE) ? Q_ONE : df_r;
    c_c   = Q_ONE - d_c;
    if (eps_r == '0) begin
      eps_c = 25'd1;
    end else begin
      eps_c = (eps_r > Q_ONE) ? Q_ONE : eps_r;
    end
  end

  logic signed [32:0] lr_q, d_q, c_q, eps_q;
  assign lr_q  = $signed({8'b0, lr_c});
  assign d_q   = $signed({8'b0, d_c});
  assign c_q   = $signed({8'b0, c_c});
  assign eps_q = $signed({8'b0, eps_c});

  // Item registers and per-entry working state.
  logic                  cmd_r;
  logic [IDX_W-1:0]      idx_r;
  logic signed [Q_W-1:0] opnd_r;
  logic signed [Q_W-1:0] vw, tw, vel, gsa, dsa;
  logic signed [Q_W-1:0] g, step, gg, t1, t2, s, ss, carry, r;
  logic [SQ_ROOT_W-1:0]  num, den;
  logic                  flag, flag_next;

  // Weight table: one row holds all five state words of an entry.
  logic             ram_we;
  logic [ROW_W-1:0] ram_rdata;

  assign ram_we = (ctl.op == OP_WRITE);

  wou_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_WEIGHTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata ({vw, tw, vel, gsa, dsa}),
    .raddr (weight_index),
    .rdata (ram_rdata)
  );

  // Negated gradient.
  logic [Q_W:0] g_sat;
  assign g_sat = sat_q(-sx42(opnd_r));

  // Multiplier with a product register; the rounded, clipped product is
  // written back in the following cycle.
  logic signed [32:0] mul_a, mul_b;
  logic               mul_go;
  mul_dst_t           mul_dst, pdst;
  logic signed [65:0] preg, rnd_sum;
  logic               pvalid;
  logic [Q_W:0]       wb;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_go  = 1'b1;
    mul_dst = DST_STEP;
    unique case (ctl.op)
      OP_MUL_STEP:  begin mul_a = lr_q;       mul_b = 33'(g);     mul_dst = DST_STEP;  end
      OP_MUL_GG:    begin mul_a = 33'(g);     mul_b = 33'(g);     mul_dst = DST_GG;    end
      OP_MUL_DG:    begin mul_a = d_q;        mul_b = 33'(gsa);   mul_dst = DST_T1;    end
      OP_MUL_CGG:   begin mul_a = c_q;        mul_b = 33'(gg);    mul_dst = DST_T2;    end
      OP_MUL_RG:    begin mul_a = 33'(r);     mul_b = 33'(g);     mul_dst = DST_S;     end
      OP_MUL_SS:    begin mul_a = 33'(s);     mul_b = 33'(s);     mul_dst = DST_SS;    end
      OP_MUL_DD:    begin mul_a = d_q;        mul_b = 33'(dsa);   mul_dst = DST_T1;    end
      OP_MUL_CSS:   begin mul_a = c_q;        mul_b = 33'(ss);    mul_dst = DST_T2;    end
      OP_MUL_CARRY: begin mul_a = d_q;        mul_b = 33'(vel);   mul_dst = DST_CARRY; end
      default:      mul_go = 1'b0;
    endcase
  end

  assign rnd_sum = preg + 66'sd8388608;
  assign wb      = sat_q($signed(rnd_sum[65:24]));

  // Saturating adder shared by all state updates.
  logic signed [41:0] sum_a, sum_b, sum_c;
  logic               sum_go;
  logic [Q_W:0]       sum_res;

  always_comb begin
    sum_a  = '0;
    sum_b  = '0;
    sum_c  = '0;
    sum_go = 1'b1;
    unique case (ctl.op)
      OP_GSUM: begin sum_a = sx42(t1); sum_b = sx42(t2); end
      OP_DSUM: begin sum_a = sx42(t1); sum_b = sx42(t2); end
      OP_VEL: begin
        sum_a = sx42(carry);
        sum_b = sx42(step);
        sum_c = (mode_r == MODE_BOTH) ? sx42(s) : '0;
      end
      OP_TRUE: begin sum_a = sx42(tw); sum_b = sx42(vel);   end
      OP_VIS:  begin sum_a = sx42(tw); sum_b = sx42(carry); end
      OP_PLAIN: begin
        sum_a = sx42(vw);
        sum_b = (mode_r == MODE_PLAIN) ? sx42(step) : sx42(s);
      end
      default: sum_go = 1'b0;
    endcase
  end

  assign sum_res = sat_q(sum_a + sum_b + sum_c);

  // Bit-serial square root, one result bit per cycle.
  logic [SQ_RAD_W-1:0]  sq_rad;
  logic [30:0]          sq_rem, sq_rem_sh, sq_trial;
  logic [SQ_ROOT_W-1:0] sq_root, sq_root_n;
  logic [SQ_CNT_W-1:0]  sq_cnt;
  logic                 sq_run, sq_done, sq_ge, sq_last, sq_to_den;
  logic signed [32:0]   sq_arg;
  logic                 sq_go;

  assign sq_go     = (ctl.op == OP_SQN_GO) || (ctl.op == OP_SQD_GO);
  assign sq_arg    = ((ctl.op == OP_SQD_GO) ? 33'(gsa) : 33'(dsa)) + eps_q;
  assign sq_rem_sh = {sq_rem[28:0], sq_rad[SQ_RAD_W-1 -: 2]};
  assign sq_trial  = {1'b0, sq_root, 2'b01};
  assign sq_ge     = (sq_rem_sh >= sq_trial);
  assign sq_root_n = {sq_root[SQ_ROOT_W-2:0], sq_ge};
  assign sq_last   = sq_run && (sq_cnt == SQ_CNT_W'(SQ_ROOT_W - 1));

  // Restoring divider for the ratio of roots, one quotient bit per cycle.
  logic [DIV_BITS-1:0]  dv_dend;
  logic [SQ_ROOT_W:0]   dv_rem, dv_rem_sh;
  logic [Q_W-1:0]       dv_q, dv_q_n;
  logic [DIV_CNT_W-1:0] dv_cnt;
  logic                 dv_run, dv_done, dv_ge, dv_ovf, dv_ovf_n, dv_last, dv_sat;

  assign dv_rem_sh = {dv_rem[SQ_ROOT_W-1:0], dv_dend[DIV_BITS-1]};
  assign dv_ge     = (dv_rem_sh >= {1'b0, den});
  assign dv_q_n    = {dv_q[Q_W-2:0], dv_ge};
  assign dv_ovf_n  = dv_ovf | dv_q[Q_W-1];
  assign dv_last   = dv_run && (dv_cnt == DIV_CNT_W'(DIV_BITS - 1));
  assign dv_sat    = dv_ovf_n | dv_q_n[Q_W-1];

  // Sticky saturation flag of the current item.
  always_comb begin
    flag_next = flag;
    if (ctl.op == OP_ACCEPT) begin
      flag_next = 1'b0;
    end else begin
      if (ctl.op == OP_LATCH && cmd_r == CMD_UPDATE && g_sat[Q_W]) begin
        flag_next = 1'b1;
      end
      if (pvalid && wb[Q_W]) begin
        flag_next = 1'b1;
      end
      if (sum_go && sum_res[Q_W]) begin
        flag_next = 1'b1;
      end
      if (dv_last && dv_sat) begin
        flag_next = 1'b1;
      end
    end
  end

  // Control state of the iterative units.
  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid  <= 1'b0;
      sq_run  <= 1'b0;
      sq_done <= 1'b0;
      sq_cnt  <= '0;
      dv_run  <= 1'b0;
      dv_done <= 1'b0;
      dv_cnt  <= '0;
    end else begin
      pvalid <= mul_go;
      if (sq_go) begin
        sq_run  <= 1'b1;
        sq_done <= 1'b0;
        sq_cnt  <= '0;
      end else if (sq_run) begin
        sq_cnt <= sq_cnt + 1'b1;
        if (sq_last) begin
          sq_run  <= 1'b0;
          sq_done <= 1'b1;
        end
      end
      if (ctl.op == OP_DIV_GO) begin
        dv_run  <= 1'b1;
        dv_done <= 1'b0;
        dv_cnt  <= '0;
      end else if (dv_run) begin
        dv_cnt <= dv_cnt + 1'b1;
        if (dv_last) begin
          dv_run  <= 1'b0;
          dv_done <= 1'b1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    flag <= flag_next;
    if (mul_go) begin
      preg <= mul_a * mul_b;
      pdst <= mul_dst;
    end
    if (pvalid) begin
      unique case (pdst)
        DST_STEP:  step  <= wb[Q_W-1:0];
        DST_GG:    gg    <= wb[Q_W-1:0];
        DST_T1:    t1    <= wb[Q_W-1:0];
        DST_T2:    t2    <= wb[Q_W-1:0];
        DST_S:     s     <= wb[Q_W-1:0];
        DST_SS:    ss    <= wb[Q_W-1:0];
        DST_CARRY: carry <= wb[Q_W-1:0];
        default:   carry <= carry;
      endcase
    end
    if (sq_go) begin
      sq_rad    <= (sq_arg > 33'sd0) ? {sq_arg[Q_W-1:0], 24'b0} : '0;
      sq_rem    <= '0;
      sq_root   <= '0;
      sq_to_den <= (ctl.op == OP_SQD_GO);
    end else if (sq_run) begin
      sq_rad  <= {sq_rad[SQ_RAD_W-3:0], 2'b00};
      sq_rem  <= sq_ge ? (sq_rem_sh - sq_trial) : sq_rem_sh;
      sq_root <= sq_root_n;
      if (sq_last) begin
        if (sq_to_den) begin
          den <= sq_root_n;
        end else begin
          num <= sq_root_n;
        end
      end
    end
    if (ctl.op == OP_DIV_GO) begin
      dv_dend <= {num, 24'b0};
      dv_rem  <= '0;
      dv_q    <= '0;
      dv_ovf  <= 1'b0;
    end else if (dv_run) begin
      dv_dend <= {dv_dend[DIV_BITS-2:0], 1'b0};
      dv_rem  <= dv_ge ? (dv_rem_sh - {1'b0, den}) : dv_rem_sh;
      dv_q    <= dv_q_n;
      dv_ovf  <= dv_ovf_n;
      if (dv_last) begin
        r <= dv_sat ? 32'sh7FFF_FFFF : $signed(dv_q_n);
      end
    end
    unique case (ctl.op)
      OP_ACCEPT: begin
        cmd_r  <= cmd;
        idx_r  <= weight_index;
        opnd_r <= operand_value;
      end
      OP_LATCH: begin
        g <= g_sat[Q_W-1:0];
        if (cmd_r == CMD_LOAD) begin
          vw  <= opnd_r;
          tw  <= opnd_r;
          vel <= '0;
          gsa <= {7'b0, eps_c};
          dsa <= {7'b0, eps_c};
        end else begin
          {vw, tw, vel, gsa, dsa} <= ram_rdata;
        end
      end
      OP_GSUM:  gsa <= sum_res[Q_W-1:0];
      OP_DSUM:  dsa <= sum_res[Q_W-1:0];
      OP_VEL:   vel <= sum_res[Q_W-1:0];
      OP_TRUE:  tw  <= sum_res[Q_W-1:0];
      OP_VIS:   vw  <= sum_res[Q_W-1:0];
      OP_PLAIN: vw  <= sum_res[Q_W-1:0];
      default:  vw  <= vw;
    endcase
  end

  assign status.mode     = mode_r;
  assign status.is_load  = cmd_r;
  assign status.sq_done  = sq_done;
  assign status.div_done = dv_done;

  assign result_index = idx_r;
  assign new_weight   = vw;
  assign saturated    = flag;

endmodule
`default_nettype wire

// ===== hdl/weight_optimizer_update_core.sv =====
// Top level of the weight optimizer update block: controller, datapath and weight table.
`default_nettype none
// The block holds a table of 1024 weights, each with a visible weight, a true
// weight, a velocity and two running averages, all signed Q8.24. An item is a
// transfer taken when start is high and busy is low: a load sets an entry, an
// update applies the rule chosen by the mode register (plain descent, Nesterov
// momentum, AdaDelta, or AdaDelta with momentum) to one gradient. Every item
// gives exactly one result, shown on result_index, new_weight and saturated
// for the single cycle in which done is high; the receiver cannot stall, so it
// must take the result in that cycle. Items are worked one at a time. An
// AdaDelta update, with or without momentum, runs two bit-serial square roots
// of 28 steps each and a restoring divide of 52 steps around a single shared
// 33 by 33 multiplier. Entries must be loaded before they are updated; the
// table is not cleared at reset. Configuration writes are always accepted
// (cfg_ready is tied high) and are to be made only while the block is idle.
module weight_optimizer_update_core import wou_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  cmd,
  input  wire logic [IDX_W-1:0]      weight_index,
  input  wire logic signed [Q_W-1:0] operand_value,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  output logic                       done,
  output logic [IDX_W-1:0]           result_index,
  output logic signed [Q_W-1:0]      new_weight,
  output logic                       saturated
);

  dp_cmd_t    ctl;
  dp_status_t status;

  // Register writes complete in the cycle they are offered.
  assign cfg_ready = 1'b1;

  wou_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .ctl    (ctl),
    .busy   (busy),
    .done   (done)
  );

  wou_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .status        (status),
    .cmd           (cmd),
    .weight_index  (weight_index),
    .operand_value (operand_value),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result_index  (result_index),
    .new_weight    (new_weight),
    .saturated     (saturated)
  );

endmodule
`default_nettype wire

// ===== test/weight_optimizer_update_core_test.sv =====
// Self-checking testbench for the weight optimizer update core.
`default_nettype none
// The test runs the core through a series of register settings that cover all
// four update rules and the extreme values of the learning rate, the decay and
// epsilon, including values above the legal range. Each setting is one phase.
// A phase starts with a few updates on the table corners with extreme gradients,
// then continues with random loads and updates. The random updates mostly hit a
// small pool of loaded entries, so the running averages and velocities build up
// over many steps. An update is only ever sent to an entry that was loaded
// earlier, since the table is not cleared at reset.
//
// A predictor keeps its own copy of the weight table and of the registers. It
// computes the expected result at the edge on which an item transfer happens.
// The monitor compares every done strobe against the oldest expected result.
// Registers are written only while the core is idle, between phases.
module weight_optimizer_update_core_test;
  import wou_pkg::*;

  typedef struct {
    logic                  op;
    logic [IDX_W-1:0]      idx;
    logic signed [Q_W-1:0] val;
  } work_item_t;

  typedef struct {
    logic [IDX_W-1:0]      idx;
    logic signed [Q_W-1:0] weight;
    logic                  sat;
  } weight_result_t;

  localparam int NUM_PHASES = 11;
  localparam int RANDOM_PER_PHASE = 63;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  cmd = CMD_LOAD;
  logic [IDX_W-1:0]      weight_index = '0;
  logic signed [Q_W-1:0] operand_value = '0;
  logic                  cfg_valid = 1'b0;
  logic [1:0]            cfg_index = REG_MODE;
  logic [CFG_W-1:0]      cfg_data = '0;
  logic                  busy, cfg_ready, done, saturated;
  logic [IDX_W-1:0]      result_index;
  logic signed [Q_W-1:0] new_weight;

  weight_optimizer_update_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .weight_index(weight_index), .operand_value(operand_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .result_index(result_index),
    .new_weight(new_weight), .saturated(saturated)
  );

  always #5 clk = ~clk;

  // Predictor state: the register copies and the per-entry optimizer state.
  logic [1:0]       mode_reg = MODE_ADADELTA;
  logic [CFG_W-1:0] lrate_reg = 25'd167772;
  logic [CFG_W-1:0] decay_reg = 25'd15099494;
  logic [CFG_W-1:0] eps_reg = 25'd17;
  logic signed [Q_W-1:0] vis_w [NUM_WEIGHTS];
  logic signed [Q_W-1:0] true_w [NUM_WEIGHTS];
  logic signed [Q_W-1:0] vel [NUM_WEIGHTS];
  logic signed [Q_W-1:0] grad_avg [NUM_WEIGHTS];
  logic signed [Q_W-1:0] delta_avg [NUM_WEIGHTS];
  bit clip_hit;

  work_item_t     pending_items[$];
  weight_result_t expected_weights[$];
  work_item_t     feed_item;
  bit             accepted = 1'b0;
  int             idle_pct = 30;
  int             mismatches = 0;
  int             results_seen = 0;
  int             loads_sent = 0;
  int             updates_sent = 0;

  // Generator-side bookkeeping of which entries were loaded.
  bit             loaded [NUM_WEIGHTS];
  int             loaded_list[$];

  // Saturation helper: any clip is remembered in clip_hit for the current item.
  function automatic logic signed [Q_W-1:0] clip_q(input longint v);
    if (v > 64'sd2147483647) begin
      clip_hit = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      clip_hit = 1'b1;
      return 32'sh8000_0000;
    end
    return v[Q_W-1:0];
  endfunction

  // Q8.24 product rounded to nearest with ties upward; the arithmetic shift
  // gives the floor of the division by 2^24.
  function automatic logic signed [Q_W-1:0] fx_mul(input logic signed [Q_W-1:0] a,
                                                   input logic signed [Q_W-1:0] b);
    longint p;
    p = longint'(a) * longint'(b) + 64'sd8388608;
    return clip_q(p >>> FRAC_W);
  endfunction

  function automatic longint unsigned int_root(input longint unsigned x);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned fx_root(input longint x);
    if (x <= 0) return 0;
    return int_root(longint'(x) << FRAC_W);
  endfunction

  // Computes the result of one item and advances the predicted table.
  function automatic weight_result_t predict_weight(input logic op, input logic [IDX_W-1:0] i,
                                                    input logic signed [Q_W-1:0] val);
    weight_result_t r;
    logic signed [Q_W-1:0] lr, d, c, eps, g, stp, old_v, s, gg, ratio_q, ss, carry;
    longint unsigned num, den;
    longint ratio, nv;
    clip_hit = 1'b0;
    lr  = (lrate_reg > Q_ONE) ? Q_W'(Q_ONE) : Q_W'(lrate_reg);
    d   = (decay_reg > Q_ONE) ? Q_W'(Q_ONE) : Q_W'(decay_reg);
    eps = (eps_reg > Q_ONE) ? Q_W'(Q_ONE) : ((eps_reg == 0) ? 32'sd1 : Q_W'(eps_reg));
    c   = Q_W'(Q_ONE) - d;
    if (op == CMD_LOAD) begin
      vis_w[i] = val;
      true_w[i] = val;
      vel[i] = 0;
      grad_avg[i] = eps;
      delta_avg[i] = eps;
    end else begin
      g = clip_q(-longint'(val));
      stp = fx_mul(lr, g);
      old_v = vel[i];
      s = 0;
      if (mode_reg == MODE_ADADELTA || mode_reg == MODE_BOTH) begin
        gg = fx_mul(g, g);
        grad_avg[i] = clip_q(longint'(fx_mul(d, grad_avg[i])) + longint'(fx_mul(c, gg)));
        num = fx_root(longint'(delta_avg[i]) + longint'(eps));
        den = fx_root(longint'(grad_avg[i]) + longint'(eps));
        // A zero denominator cannot happen with epsilon of at least one, but
        // the divider then answers with the largest value.
        ratio = (den == 0) ? 64'sh7FFF_FFFF_FFFF_FFFF : longint'((num << FRAC_W) / den);
        ratio_q = clip_q(ratio);
        s = fx_mul(ratio_q, g);
        ss = fx_mul(s, s);
        delta_avg[i] = clip_q(longint'(fx_mul(d, delta_avg[i])) + longint'(fx_mul(c, ss)));
      end
      case (mode_reg)
        MODE_PLAIN: begin
          vis_w[i] = clip_q(longint'(vis_w[i]) + longint'(stp));
        end
        MODE_ADADELTA: begin
          vis_w[i] = clip_q(longint'(vis_w[i]) + longint'(s));
        end
        default: begin
          // Nesterov look-ahead: the network sees the true weight plus the
          // decayed old velocity.
          carry = fx_mul(d, old_v);
          nv = longint'(carry) + longint'(stp);
          if (mode_reg == MODE_BOTH) nv = nv + longint'(s);
          vel[i] = clip_q(nv);
          true_w[i] = clip_q(longint'(true_w[i]) + longint'(vel[i]));
          vis_w[i] = clip_q(longint'(true_w[i]) + longint'(carry));
        end
      endcase
    end
    r.idx = i;
    r.weight = vis_w[i];
    r.sat = (op == CMD_LOAD) ? 1'b0 : clip_hit;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %0s: got %0d expected %0d at %0t", what, got, want, $time);
    mismatches++;
  endtask

  // Monitor: checks the done strobe first, then records any item transfer of
  // this edge, so a result and the next transfer on one edge stay in order.
  always @(posedge clk) begin
    if (rst) begin
      accepted <= 1'b0;
    end else begin
      if (done) begin
        results_seen++;
        if (expected_weights.size() == 0) begin
          report_mismatch("unexpected result, index", result_index, -1);
        end else begin
          if (result_index !== expected_weights[0].idx)
            report_mismatch("result_index", result_index, expected_weights[0].idx);
          if (new_weight !== expected_weights[0].weight)
            report_mismatch("new_weight", new_weight, expected_weights[0].weight);
          if (saturated !== expected_weights[0].sat)
            report_mismatch("saturated", saturated, expected_weights[0].sat);
          void'(expected_weights.pop_front());
        end
      end
      if (start && !busy)
        expected_weights = {expected_weights,
                            predict_weight(cmd, weight_index, operand_value)};
      accepted <= start && !busy;
    end
  end

  // Driver: at the falling edge, holds an item until its transfer, then
  // either presents the next one or leaves a gap.
  always @(negedge clk) begin
    if (!rst && (!start || accepted)) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
        feed_item = pending_items.pop_front();
        cmd <= feed_item.op;
        weight_index <= feed_item.idx;
        operand_value <= feed_item.val;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic queue_item(input logic op, input logic [IDX_W-1:0] i,
                            input logic signed [Q_W-1:0] val);
    work_item_t it;
    it.op = op;
    it.idx = i;
    it.val = val;
    pending_items = {pending_items, it};
    if (op == CMD_LOAD) begin
      loads_sent++;
      if (!loaded[i]) begin
        loaded[i] = 1'b1;
        loaded_list = {loaded_list, int'(i)};
      end
    end else begin
      updates_sent++;
    end
  endtask

  // Operand mix: realistic gradients most of the time, plus full-range noise
  // and the two extremes.
  function automatic logic signed [Q_W-1:0] pick_operand();
    logic signed [Q_W-1:0] v;
    case ($urandom_range(5))
      0, 1: v = Q_W'($urandom_range(0, 1 << 24));
      2: v = Q_W'($urandom_range(0, 1 << 27));
      3: v = $urandom;
      4: v = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: v = Q_W'($urandom_range(0, 1 << 20));
    endcase
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  task automatic queue_random_items(input int count);
    logic [IDX_W-1:0] i;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 25) begin
        i = ($urandom_range(3) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(31));
        queue_item(CMD_LOAD, i, pick_operand());
      end else begin
        i = IDX_W'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
        queue_item(CMD_UPDATE, i, pick_operand());
      end
    end
  endtask

  // Waits until every item was transferred and every result came back.
  task automatic wait_quiet();
    while (pending_items.size() != 0 || start || expected_weights.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] ri, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= ri;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (ri)
      REG_MODE:  mode_reg = value[1:0];
      REG_LRATE: lrate_reg = value;
      REG_DECAY: decay_reg = value;
      default:   eps_reg = value;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Register settings per phase: mode, learning rate, decay, epsilon. They
  // include zero, exactly one and the all-ones value above the legal range.
  logic [1:0]       set_mode  [NUM_PHASES] = '{MODE_ADADELTA, MODE_PLAIN, MODE_NESTEROV,
      MODE_NESTEROV, MODE_ADADELTA, MODE_BOTH, MODE_BOTH, MODE_ADADELTA, MODE_PLAIN,
      MODE_NESTEROV, MODE_BOTH};
  logic [CFG_W-1:0] set_lrate [NUM_PHASES] = '{25'd167772, Q_ONE, 25'd167772, 25'h1FF_FFFF,
      25'd0, 25'd1677722, 25'd167772, 25'd167772, 25'd0, 25'd8388608, Q_ONE};
  logic [CFG_W-1:0] set_decay [NUM_PHASES] = '{25'd15099494, 25'd0, 25'd15099494, Q_ONE,
      25'd0, 25'h1FF_FFFF, 25'd15099494, 25'd8388608, 25'd0, 25'd0, 25'd0};
  logic [CFG_W-1:0] set_eps   [NUM_PHASES] = '{25'd17, 25'd1, 25'd17, 25'd0, Q_ONE,
      25'h1FF_FFFF, 25'd17, 25'd1, 25'd17, 25'd17, 25'd1};

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      // Sender gaps: 30 percent in the early phases, 46 in the middle ones,
      // none at the end.
      idle_pct = (p < 4) ? 30 : ((p < 8) ? 46 : 0);
      if (p > 0) begin
        write_register(REG_MODE, {23'd0, set_mode[p]});
        write_register(REG_LRATE, set_lrate[p]);
        write_register(REG_DECAY, set_decay[p]);
        write_register(REG_EPS, set_eps[p]);
      end else begin
        // Reset register values first, with corner entries and extreme values.
        queue_item(CMD_LOAD, 10'd0, 32'sh7FFF_FFFF);
        queue_item(CMD_LOAD, 10'd1023, 32'sh8000_0000);
        queue_item(CMD_LOAD, 10'd5, 32'sd0);
        queue_item(CMD_LOAD, 10'd682, 32'sh5555_5555);
        queue_item(CMD_LOAD, 10'd341, 32'shAAAA_AAAA);
        queue_item(CMD_UPDATE, 10'd5, 32'sd0);
        queue_item(CMD_UPDATE, 10'd5, -32'sd1);
        queue_item(CMD_UPDATE, 10'd682, 32'sh0100_0000);
        queue_item(CMD_UPDATE, 10'd341, -32'sh0100_0000);
      end
      // Extreme gradients on the corner entries under every setting.
      queue_item(CMD_UPDATE, 10'd0, 32'sh8000_0000);
      queue_item(CMD_UPDATE, 10'd1023, 32'sh7FFF_FFFF);
      queue_item(CMD_UPDATE, 10'd0, 32'sh7FFF_FFFF);
      queue_item(CMD_UPDATE, 10'd1023, 32'sh8000_0000);
      queue_random_items(RANDOM_PER_PHASE);
      wait_quiet();
    end

    repeat (200) @(posedge clk);
    $display("Covered %0d loads and %0d updates over %0d register settings,",
             loads_sent, updates_sent, NUM_PHASES);
    $display("all four update rules; %0d results checked, %0d mismatches.",
             results_seen, mismatches);
    if (mismatches == 0 && expected_weights.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: the slowest legal run stays far below this bound.
  initial begin
    #40_000_000;
    $display("Timeout with %0d results outstanding", expected_weights.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
hdl/wou_pkg.sv
hdl/wou_ram.sv
hdl/wou_ctrl.sv
hdl/wou_dp.sv
hdl/weight_optimizer_update_core.sv
test/weight_optimizer_update_core_test.sv
